// ----- rtl/core/tcpl_pkg.sv -----
// tcpl_pkg: shared types and constants for the three-class priority list
// holds field widths, opcode, class and status codes and the sequencer state type
// no dependencies
`default_nettype none

package tcpl_pkg;

  // default sizing handed to the top level
  localparam int DEF_CAPACITY = 16;
  localparam int DEF_KEY_BITS = 16;

  // port field widths
  localparam int OPC_W  = 2;
  localparam int KEY_W  = 16;
  localparam int CLS_W  = 2;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int FREE_W = 5;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // opcodes
  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ   = 2'd2;

  // priority classes
  localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_URGENT = 2'd1;
  localparam logic [CLS_W-1:0] CLS_MID    = 2'd2;
  localparam logic [CLS_W-1:0] CLS_LOW    = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_READ,
    S_READ_OUT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/three_class_priority_list.sv -----
// three_class_priority_list: ordered list of keyed entries in three urgency classes
// the list lives in one tcpl_ram (class and key per word); a sequencer scans and shifts it
// depends on tcpl_pkg and tcpl_ram
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+--------------------------
//  item in   | opcode entry_key priority_class read_position | start high and busy low
//  result    | status free_places read_key read_class        | done high for one cycle
//  config    | cfg_data                                      | cfg_write high
//
// work per item with n entries held: reads, rejected or empty items and least-urgent inserts
// need no scan; an urgent insert shifts up all n entries, a middle insert scans to the first
// least-urgent entry, then shifts up the rest, and a delete scans plus shifts down; one ram word
// moves per cycle through the single write port. busy is high from acceptance to done.
// synchronous active-high reset empties the list and sets capacity to 16; the ram
// needs no clearing. the receiver cannot stall: each result shows for one cycle.
`default_nettype none

module three_class_priority_list
  import tcpl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OPC_W-1:0]  opcode,
  input  wire logic [KEY_W-1:0]  entry_key,
  input  wire logic [CLS_W-1:0]  priority_class,
  input  wire logic [POS_W-1:0]  read_position,
  output logic                   done,
  output logic [STAT_W-1:0]      status,
  output logic [FREE_W-1:0]      free_places,
  output logic [KEY_W-1:0]       read_key,
  output logic [CLS_W-1:0]       read_class,
  input  wire logic              cfg_write,
  input  wire logic [CAP_W-1:0]  cfg_data
);

  localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int WW   = KW + CLS_W;
  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int LW   = (CW > CAP_W) ? CW : CAP_W;

  state_t state, state_next;

  logic [CW-1:0]     count;
  logic [CAP_W-1:0]  cap_reg;
  logic              is_del;
  logic [KW-1:0]     key_r;
  logic [CLS_W-1:0]  cls_r;
  logic [POS_W-1:0]  pos_r;
  logic [CW-1:0]     target;
  logic [CW-1:0]     issue;
  logic              chk_vld;
  logic [CW-1:0]     chk_idx;
  logic [STAT_W-1:0] res_status;
  logic [KW-1:0]     res_key;
  logic [CLS_W-1:0]  res_cls;

  // ram ports
  logic          ram_we;
  logic [IW-1:0] ram_wr_addr;
  logic [WW-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [IW-1:0] ram_rd_addr;
  logic [WW-1:0] ram_rd_data;

  tcpl_ram #(
    .WIDTH(WW),
    .DEPTH(CAPACITY)
  ) u_list_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // effective capacity and free places
  logic [LW-1:0] lim;
  logic [LW-1:0] cnt_w;
  logic          full;
  logic          pos_ok;
  logic          match;
  logic          found;
  logic          scan_end;

  always_comb begin
    cnt_w = LW'(count);
    if (cap_reg == '0) begin
      lim = LW'(1);
    end else if (LW'(cap_reg) > LW'(CAPACITY)) begin
      lim = LW'(CAPACITY);
    end else begin
      lim = LW'(cap_reg);
    end
    full   = cnt_w >= lim;
    pos_ok = CMPW'(read_position) < CMPW'(count);
  end

  assign free_places = (lim > cnt_w) ? FREE_W'(lim - cnt_w) : '0;

  // scan compare on the word that just came out of the ram
  assign match    = is_del ? (ram_rd_data[KW-1:0] == key_r)
                           : (ram_rd_data[WW-1:KW] == CLS_LOW);
  assign found    = chk_vld && match;
  assign scan_end = !chk_vld && (issue >= count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_INSERT: begin
              if (priority_class == CLS_NONE || full) begin
                state_next = S_DONE;
              end else if (priority_class == CLS_MID && count != '0) begin
                state_next = S_SEARCH;
              end else begin
                state_next = S_SHIFT_UP;
              end
            end
            OP_DELETE: state_next = (count == '0) ? S_DONE : S_SEARCH;
            OP_READ:   state_next = pos_ok ? S_READ : S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_SEARCH: begin
        if (found) begin
          state_next = is_del ? S_SHIFT_DN : S_SHIFT_UP;
        end else if (scan_end) begin
          state_next = is_del ? S_DONE : S_SHIFT_UP;
        end
      end
      S_SHIFT_UP: begin
        if (!chk_vld && issue == target) state_next = S_DONE;
      end
      S_SHIFT_DN: begin
        if (scan_end) state_next = S_DONE;
      end
      S_READ:     state_next = S_READ_OUT;
      S_READ_OUT: state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // ram control per state
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    ram_we      = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    case (state)
      S_SEARCH: begin
        ram_rd_en   = issue < count;
        ram_rd_addr = IW'(issue);
      end
      S_SHIFT_UP: begin
        // move entry issue-1 up to issue, then drop the new item into the gap
        ram_rd_en   = issue > target;
        ram_rd_addr = IW'(issue - CW'(1));
        if (chk_vld) begin
          ram_we      = 1'b1;
          ram_wr_addr = IW'(chk_idx);
          ram_wr_data = ram_rd_data;
        end else if (issue == target) begin
          ram_we      = 1'b1;
          ram_wr_addr = IW'(target);
          ram_wr_data = {cls_r, key_r};
        end
      end
      S_SHIFT_DN: begin
        // move entry issue down to issue-1
        ram_rd_en   = issue < count;
        ram_rd_addr = IW'(issue);
        if (chk_vld) begin
          ram_we      = 1'b1;
          ram_wr_addr = IW'(chk_idx);
          ram_wr_data = ram_rd_data;
        end
      end
      S_READ: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = IW'(pos_r);
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      cap_reg <= CAP_RESET;
      chk_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) cap_reg <= cfg_data;
      case (state)
        S_IDLE: begin
          chk_vld <= 1'b0;
        end
        S_SEARCH: begin
          if (found || scan_end) begin
            chk_vld <= 1'b0;
          end else begin
            chk_vld <= issue < count;
          end
        end
        S_SHIFT_UP: begin
          chk_vld <= issue > target;
          if (!chk_vld && issue == target) count <= count + CW'(1);
        end
        S_SHIFT_DN: begin
          chk_vld <= issue < count;
          if (scan_end) count <= count - CW'(1);
        end
        default: begin
          chk_vld <= 1'b0;
        end
      endcase
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          is_del     <= opcode == OP_DELETE;
          key_r      <= entry_key[KW-1:0];
          cls_r      <= priority_class;
          pos_r      <= read_position;
          target     <= (priority_class == CLS_URGENT) ? '0 : count;
          issue      <= (opcode == OP_INSERT && priority_class != CLS_MID) ? count : '0;
          res_key    <= '0;
          res_cls    <= CLS_NONE;
          res_status <= ST_OK;
          case (opcode)
            OP_INSERT: if (priority_class != CLS_NONE && full) res_status <= ST_FULL;
            OP_DELETE: if (count == '0) res_status <= ST_NOTFOUND;
            OP_READ:   if (!pos_ok) res_status <= ST_EMPTY;
            default:   res_status <= ST_OK;
          endcase
        end
      end
      S_SEARCH: begin
        chk_idx <= issue;
        if (found) begin
          target <= chk_idx;
          if (is_del) begin
            res_key <= ram_rd_data[KW-1:0];
            res_cls <= ram_rd_data[WW-1:KW];
            issue   <= chk_idx + CW'(1);
          end else begin
            issue <= count;
          end
        end else if (scan_end) begin
          target <= count;
          issue  <= count;
          if (is_del) res_status <= ST_NOTFOUND;
        end else if (issue < count) begin
          issue <= issue + CW'(1);
        end
      end
      S_SHIFT_UP: begin
        chk_idx <= issue;
        if (issue > target) issue <= issue - CW'(1);
      end
      S_SHIFT_DN: begin
        chk_idx <= issue - CW'(1);
        if (issue < count) issue <= issue + CW'(1);
      end
      S_READ_OUT: begin
        res_key <= ram_rd_data[KW-1:0];
        res_cls <= ram_rd_data[WW-1:KW];
      end
      default: begin
        chk_idx <= chk_idx;
      end
    endcase
  end

  // port drive
  assign busy       = state != S_IDLE;
  assign done       = state == S_DONE;
  assign status     = res_status;
  assign read_key   = KEY_W'(res_key);
  assign read_class = res_cls;

  // checks
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(CAPACITY) >= count)
    else $error("entry count beyond capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_rd_en && ram_wr_addr == ram_rd_addr))
    else $error("ram read and write on the same entry in one cycle");

endmodule

`default_nettype wire

// ----- rtl/core/tcpl_ram.sv -----
// tcpl_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// no dependencies
`default_nettype none

module tcpl_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- test/three_class_priority_list_test.sv -----
// three_class_priority_list_test: self-checking bench for the three-class priority list
// drives directed then random insert/delete/read items across several capacity settings
// depends on tcpl_pkg and three_class_priority_list
`timescale 1ns / 1ps

module three_class_priority_list_test;
  import tcpl_pkg::*;

  localparam int LIST_DEPTH     = DEF_CAPACITY;
  localparam int RANDOM_ITEMS   = 1530;
  localparam int PHASE_COUNT    = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PRINT_LIMIT    = 50;

  // opcode three does nothing
  localparam logic [OPC_W-1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic [CLS_W-1:0] cls;
    logic [POS_W-1:0] pos;
  } list_op_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FREE_W-1:0] free;
    logic [KEY_W-1:0]  key;
    logic [CLS_W-1:0]  cls;
  } list_result_t;

  typedef struct packed {
    list_op_t     op;
    logic         fixed;
    list_result_t want;
  } directed_row_t;

  localparam list_result_t ANY_RESULT = '0;
  localparam int DIRECTED_ROWS = 24;

  // opening rows carry typed expectations, the rest go through the list predictor
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // empty list after reset
    '{'{OP_READ,   16'h0000, CLS_NONE,   4'd0},  1'b1, '{ST_EMPTY, 5'd16, 16'h0000, CLS_NONE}},
    '{'{OP_DELETE, 16'h0000, CLS_NONE,   4'd0},  1'b1,
      '{ST_NOTFOUND, 5'd16, 16'h0000, CLS_NONE}},
    // class zero insert is dropped silently
    '{'{OP_INSERT, 16'h1234, CLS_NONE,   4'd0},  1'b1, '{ST_OK, 5'd16, 16'h0000, CLS_NONE}},
    // opcode three is a no-op
    '{'{OP_NOP,    16'hFFFF, CLS_LOW,    4'd15}, 1'b1, '{ST_OK, 5'd16, 16'h0000, CLS_NONE}},
    '{'{OP_INSERT, 16'hFFFF, CLS_LOW,    4'd15}, 1'b1, '{ST_OK, 5'd15, 16'h0000, CLS_NONE}},
    // middle lands before the first least-urgent entry, urgent at the head
    '{'{OP_INSERT, 16'h0000, CLS_MID,    4'd0},  1'b0, ANY_RESULT},
    '{'{OP_INSERT, 16'h0001, CLS_URGENT, 4'd0},  1'b0, ANY_RESULT},
    '{'{OP_INSERT, 16'h0002, CLS_URGENT, 4'd0},  1'b0, ANY_RESULT},
    '{'{OP_INSERT, 16'h0003, CLS_LOW,    4'd0},  1'b0, ANY_RESULT},
    '{'{OP_INSERT, 16'h0004, CLS_MID,    4'd0},  1'b0, ANY_RESULT},
    '{'{OP_READ,   16'h0000, CLS_NONE,   4'd0},  1'b0, ANY_RESULT},
    '{'{OP_READ,   16'h0000, CLS_NONE,   4'd1},  1'b0, ANY_RESULT},
    '{'{OP_READ,   16'h0000, CLS_NONE,   4'd2},  1'b0, ANY_RESULT},
    '{'{OP_READ,   16'h0000, CLS_NONE,   4'd3},  1'b0, ANY_RESULT},
    '{'{OP_READ,   16'h0000, CLS_NONE,   4'd5},  1'b0, ANY_RESULT},
    '{'{OP_READ,   16'h0000, CLS_NONE,   4'd6},  1'b0, ANY_RESULT},
    '{'{OP_READ,   16'h0000, CLS_NONE,   4'd15}, 1'b0, ANY_RESULT},
    // delete at tail, head, and a missing key
    '{'{OP_DELETE, 16'h0003, CLS_NONE,   4'd0},  1'b0, ANY_RESULT},
    '{'{OP_DELETE, 16'h0002, CLS_NONE,   4'd0},  1'b0, ANY_RESULT},
    '{'{OP_DELETE, 16'hAAAA, CLS_NONE,   4'd0},  1'b0, ANY_RESULT},
    // duplicate keys: delete takes the first one
    '{'{OP_INSERT, 16'h5555, CLS_LOW,    4'd0},  1'b0, ANY_RESULT},
    '{'{OP_INSERT, 16'h5555, CLS_URGENT, 4'd0},  1'b0, ANY_RESULT},
    '{'{OP_DELETE, 16'h5555, CLS_NONE,   4'd0},  1'b0, ANY_RESULT},
    '{'{OP_DELETE, 16'hFFFF, CLS_NONE,   4'd0},  1'b0, ANY_RESULT}
  };

  // capacity per random phase: extremes, out-of-range values, and drops below the fill
  localparam logic [CAP_W-1:0] PHASE_CAPS [PHASE_COUNT] = '{
    5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd12, 5'd2, 5'd16, 5'd7, 5'd5
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [OPC_W-1:0]  opcode = OP_INSERT;
  logic [KEY_W-1:0]  entry_key = '0;
  logic [CLS_W-1:0]  priority_class = CLS_NONE;
  logic [POS_W-1:0]  read_position = '0;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [FREE_W-1:0] free_places;
  logic [KEY_W-1:0]  read_key;
  logic [CLS_W-1:0]  read_class;
  logic              cfg_write = 1'b0;
  logic [CAP_W-1:0]  cfg_data = CAP_RESET;

  three_class_priority_list DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .entry_key      (entry_key),
    .priority_class (priority_class),
    .read_position  (read_position),
    .done           (done),
    .status         (status),
    .free_places    (free_places),
    .read_key       (read_key),
    .read_class     (read_class),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the list
  logic [KEY_W-1:0] held_keys [LIST_DEPTH];
  logic [CLS_W-1:0] held_classes [LIST_DEPTH];
  int               held_count = 0;
  logic [CAP_W-1:0] capacity_setting = CAP_RESET;

  list_result_t pending_results [$];
  int mismatches = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int full_hits = 0;
  int notfound_hits = 0;
  int empty_hits = 0;
  int deepest = 0;
  int cap_writes = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("tb: mismatch at %0t ns: %s", $time, what);
  endtask

  // apply one item to the shadow list and return the result it must produce
  function automatic list_result_t apply_list_op(input list_op_t it);
    list_result_t r;
    int lim;
    int at;
    int i;
    bit found;
    r = '0;
    found = 1'b0;
    lim = (capacity_setting == 0) ? 1 :
          (int'(capacity_setting) > LIST_DEPTH ? LIST_DEPTH : int'(capacity_setting));
    case (it.op)
      OP_INSERT: begin
        if (it.cls != CLS_NONE) begin
          if (held_count >= lim) begin
            r.status = ST_FULL;
          end else begin
            at = held_count;
            if (it.cls == CLS_URGENT) begin
              at = 0;
            end else if (it.cls == CLS_MID) begin
              // scan backward so the first least-urgent entry wins
              for (i = held_count - 1; i >= 0; i--)
                if (held_classes[i] == CLS_LOW) at = i;
            end
            for (i = held_count; i > at; i--) begin
              held_keys[i]    = held_keys[i-1];
              held_classes[i] = held_classes[i-1];
            end
            held_keys[at]    = it.key;
            held_classes[at] = it.cls;
            held_count++;
          end
        end
      end
      OP_DELETE: begin
        at = 0;
        for (i = 0; i < held_count; i++)
          if (!found && held_keys[i] == it.key) begin
            at = i;
            found = 1'b1;
          end
        if (!found) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.key = held_keys[at];
          r.cls = held_classes[at];
          for (i = at; i + 1 < held_count; i++) begin
            held_keys[i]    = held_keys[i+1];
            held_classes[i] = held_classes[i+1];
          end
          held_count--;
        end
      end
      OP_READ: begin
        if (int'(it.pos) < held_count) begin
          r.key = held_keys[it.pos];
          r.cls = held_classes[it.pos];
        end else begin
          r.status = ST_EMPTY;
        end
      end
      default: ;
    endcase
    r.free = (held_count >= lim) ? '0 : FREE_W'(lim - held_count);
    return r;
  endfunction

  // keys: small pool for duplicates, the extremes, or anything
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return KEY_W'($urandom_range(0, 7));
    if (sel < 36) return '1;
    if (sel < 40) return '0;
    return KEY_W'($urandom);
  endfunction

  // random item; deletes and reads mostly aim at entries that are held
  function automatic list_op_t random_list_op(input int insert_pct);
    list_op_t it;
    int sel;
    it.key = pick_key();
    it.cls = ($urandom_range(0, 19) == 0) ? CLS_NONE : CLS_W'($urandom_range(1, 3));
    it.pos = POS_W'($urandom_range(0, 15));
    sel = $urandom_range(0, 99);
    if (sel < insert_pct) begin
      it.op = OP_INSERT;
    end else begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        it.op = OP_DELETE;
        if (held_count > 0 && $urandom_range(0, 9) < 7)
          it.key = held_keys[$urandom_range(0, held_count - 1)];
      end else if (sel < 9) begin
        it.op = OP_READ;
        if (held_count > 0 && $urandom_range(0, 9) < 7)
          it.pos = POS_W'($urandom_range(0, held_count - 1));
      end else begin
        it.op = OP_NOP;
      end
    end
    return it;
  endfunction

  // offer one item, wait for acceptance, then maybe open a gap
  task automatic send_item(input list_op_t it, input bit fixed, input list_result_t want);
    list_result_t exp_res;
    start          <= 1'b1;
    opcode         <= it.op;
    entry_key      <= it.key;
    priority_class <= it.cls;
    read_position  <= it.pos;
    do @(posedge clk); while (busy);
    exp_res = apply_list_op(it);
    if (fixed) exp_res = want;
    pending_results.push_back(exp_res);
    items_accepted++;
    if (exp_res.status == ST_FULL) full_hits++;
    if (exp_res.status == ST_NOTFOUND) notfound_hits++;
    if (exp_res.status == ST_EMPTY) empty_hits++;
    if (held_count > deepest) deepest = held_count;
    // sender bursts and gaps
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    capacity_setting = value;
    cap_writes++;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    list_result_t want;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: watchdog expired with %0d results outstanding", pending_results.size());
        $display("tb: failure");
        $finish;
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (free_places !== want.free)
            report_mismatch($sformatf("free_places %0d, expected %0d", free_places, want.free));
          if (read_key !== want.key)
            report_mismatch($sformatf("read_key %h, expected %h", read_key, want.key));
          if (read_class !== want.cls)
            report_mismatch($sformatf("read_class %0d, expected %0d", read_class, want.cls));
        end
      end
    end
  end

  // stimulus
  initial begin
    int p;
    int n;
    int insert_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at the reset capacity
    for (n = 0; n < DIRECTED_ROWS; n++)
      send_item(DIRECTED[n].op, DIRECTED[n].fixed, DIRECTED[n].want);
    drain_results();

    // random phases, each under its own capacity
    for (p = 0; p < PHASE_COUNT; p++) begin
      write_capacity(PHASE_CAPS[p]);
      insert_pct = $urandom_range(35, 75);
      for (n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++)
        send_item(random_list_op(insert_pct), 1'b0, ANY_RESULT);
      drain_results();
    end

    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d items, %0d results checked, %0d capacity writes, deepest list %0d",
             items_accepted, results_checked, cap_writes, deepest);
    $display("tb: %0d full, %0d not found, %0d empty position, %0d mismatches",
             full_hits, notfound_hits, empty_hits, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tcpl_pkg.sv
rtl/core/tcpl_ram.sv
rtl/core/three_class_priority_list.sv
test/three_class_priority_list_test.sv
